### rtl/assert_macros.svh
// Assertion macros for the bind slot table.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BST_ASSERT_IMP(label, ante, cons, msg) \
    `BST_ASSERT(label, (ante) |-> (cons), msg)

`endif

### rtl/bst_pkg.sv
// Shared types and constants for the bind slot table.
// No dependencies.
package bst_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int ID_BITS_DEF = 32;
    localparam int OBJ_W       = 32;
    localparam int SIDX_W      = 5;
    localparam int RSLOT_W     = 4;
    localparam int OPC_W       = 3;
    localparam int QDEPTH      = 2;

    typedef enum logic [OPC_W-1:0] {
        OPC_BIND        = 3'd0,
        OPC_BIND_SLOT   = 3'd1,
        OPC_UNBIND_ID   = 3'd2,
        OPC_UNBIND_SLOT = 3'd3,
        OPC_UNBIND_ALL  = 3'd4,
        OPC_QUERY       = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NULL     = 3'd1,
        ST_NOFREE   = 3'd2,
        ST_BADSLOT  = 3'd3,
        ST_NOTBOUND = 3'd4,
        ST_ALREADY  = 3'd5,
        ST_EMPTY    = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        K_BIND,
        K_BIND_SLOT,
        K_UNBIND_ID,
        K_UNBIND_SLOT,
        K_UNBIND_ALL,
        K_QUERY,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic              null_id;
        logic              slot_ok;
        logic              scan;
        logic [SIDX_W-1:0] sidx;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } back_state_t;

endpackage

### rtl/bind_slot_table.sv
// Top level of the bind slot table: front end, command queue, back end.
// Depends on bst_pkg, bst_front, bst_queue, bst_back and assert_macros.svh.
//
// Usage:
//   Request words enter through push/full; a word is taken on a clock edge
//   with push high and full low. Fields: opcode, object_id, slot_index.
//   Result words leave through empty/pop; the oldest result sits on found,
//   result_slot and status while empty is low and is taken on an edge with
//   pop high. Every request yields exactly one result, in order.
//   Scan: ops that look up an id (bind, bind to slot, unbind id and query
//   with a non-null id) walk the slot store one entry per cycle, stopping
//   early when the id is found; all other ops skip the scan. The single
//   read port of the object store sets the scan length. The back end takes
//   the next request from the queue only once the current result is written.
//   A request is written into the command queue before the back end takes it.
//   A small command queue lets requests enter while a lookup runs or a
//   result waits; when the result is not popped the back end holds and the
//   queue fills, then full rises.
//   Reset empties every slot, the queue and the result register at once.
`include "assert_macros.svh"

module bind_slot_table #(
    parameter int SLOTS   = bst_pkg::SLOTS_DEF,
    parameter int ID_BITS = bst_pkg::ID_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [bst_pkg::OPC_W-1:0]   opcode,
    input  logic [bst_pkg::OBJ_W-1:0]   object_id,
    input  logic [bst_pkg::SIDX_W-1:0]  slot_index,
    output logic                        empty,
    input  logic                        pop,
    output logic                        found,
    output logic [bst_pkg::RSLOT_W-1:0] result_slot,
    output logic [2:0]                  status
);

    localparam int ID_W = (ID_BITS < bst_pkg::OBJ_W) ? ID_BITS : bst_pkg::OBJ_W;
    localparam int QW   = $bits(bst_pkg::cmd_t) + ID_W;

    bst_pkg::cmd_t    f_cmd;
    logic [ID_W-1:0]  f_id;
    bst_pkg::cmd_t    b_cmd;
    logic [ID_W-1:0]  b_id;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    logic [QW-1:0]    q_wdata;
    logic [QW-1:0]    q_rdata;
    bst_pkg::status_t b_status;
    logic             b_fail;

    assign q_wdata = {f_cmd, f_id};
    assign b_cmd   = bst_pkg::cmd_t'(q_rdata[QW-1:ID_W]);
    assign b_id    = q_rdata[ID_W-1:0];
    assign status  = b_status;
    assign b_fail  = (b_status == bst_pkg::ST_NULL) || (b_status == bst_pkg::ST_NOFREE) ||
                     (b_status == bst_pkg::ST_BADSLOT) || (b_status == bst_pkg::ST_NOTBOUND) ||
                     (b_status == bst_pkg::ST_EMPTY);

    bst_front #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_front (
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .object_id  (object_id),
        .slot_index (slot_index),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (f_cmd),
        .q_id       (f_id)
    );

    bst_queue #(
        .WIDTH (QW),
        .DEPTH (bst_pkg::QDEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    bst_back #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_cmd       (b_cmd),
        .q_id        (b_id),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .found       (found),
        .result_slot (result_slot),
        .status      (b_status)
    );

    `BST_ASSERT(a_queue_flags, !(q_full && q_empty), "queue both full and empty")
    `BST_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty, "back end popped an empty queue")
    `BST_ASSERT_IMP(a_slot_zero, !empty && !found, result_slot == '0, "slot set without found")
    `BST_ASSERT_IMP(a_fail_no_slot, !empty && b_fail, !found, "failure status with found set")

endmodule

### rtl/bst_front.sv
// Front end: accepts request words and classifies them into commands.
// Depends on bst_pkg.
module bst_front #(
    parameter int SLOTS   = bst_pkg::SLOTS_DEF,
    parameter int ID_BITS = bst_pkg::ID_BITS_DEF
) (
    input  logic                          push,
    output logic                          full,
    input  logic [bst_pkg::OPC_W-1:0]     opcode,
    input  logic [bst_pkg::OBJ_W-1:0]     object_id,
    input  logic [bst_pkg::SIDX_W-1:0]    slot_index,
    input  logic                          q_full,
    output logic                          q_push,
    output bst_pkg::cmd_t                 q_cmd,
    output logic [((ID_BITS < bst_pkg::OBJ_W) ? ID_BITS : bst_pkg::OBJ_W)-1:0] q_id
);

    localparam int ID_W = (ID_BITS < bst_pkg::OBJ_W) ? ID_BITS : bst_pkg::OBJ_W;

    logic [ID_W-1:0] id;
    logic            null_id;
    logic            needs_id;

    assign full    = q_full;
    assign q_push  = push && !q_full;
    assign id      = object_id[ID_W-1:0];
    assign null_id = (id == '0);
    assign q_id    = id;

    always_comb
    begin
        q_cmd.null_id = null_id;
        q_cmd.slot_ok = ({1'b0, slot_index} < (bst_pkg::SIDX_W + 1)'(SLOTS));
        q_cmd.sidx    = slot_index;
        needs_id      = 1'b0;
        unique case (bst_pkg::opcode_t'(opcode))
            bst_pkg::OPC_BIND:
            begin
                q_cmd.kind = bst_pkg::K_BIND;
                needs_id   = 1'b1;
            end
            bst_pkg::OPC_BIND_SLOT:
            begin
                q_cmd.kind = bst_pkg::K_BIND_SLOT;
                needs_id   = 1'b1;
            end
            bst_pkg::OPC_UNBIND_ID:
            begin
                q_cmd.kind = bst_pkg::K_UNBIND_ID;
                needs_id   = 1'b1;
            end
            bst_pkg::OPC_UNBIND_SLOT: q_cmd.kind = bst_pkg::K_UNBIND_SLOT;
            bst_pkg::OPC_UNBIND_ALL:  q_cmd.kind = bst_pkg::K_UNBIND_ALL;
            bst_pkg::OPC_QUERY:
            begin
                q_cmd.kind = bst_pkg::K_QUERY;
                needs_id   = 1'b1;
            end
            default:                  q_cmd.kind = bst_pkg::K_NOP;
        endcase
        // id lookup only for id-based ops with a non-null id
        q_cmd.scan = needs_id && !null_id;
    end

endmodule

### rtl/bst_queue.sv
// Small command queue between the front end and the back end.
// Depends on bst_pkg for its default depth.
module bst_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bst_pkg::QDEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/bst_back.sv
// Back end: slot table, sequential id scan, update and result register.
// Depends on bst_pkg.
module bst_back #(
    parameter int SLOTS   = bst_pkg::SLOTS_DEF,
    parameter int ID_BITS = bst_pkg::ID_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  bst_pkg::cmd_t                 q_cmd,
    input  logic [((ID_BITS < bst_pkg::OBJ_W) ? ID_BITS : bst_pkg::OBJ_W)-1:0] q_id,
    output logic                          q_pop,
    input  logic                          pop,
    output logic                          empty,
    output logic                          found,
    output logic [bst_pkg::RSLOT_W-1:0]   result_slot,
    output bst_pkg::status_t              status
);

    localparam int ID_W   = (ID_BITS < bst_pkg::OBJ_W) ? ID_BITS : bst_pkg::OBJ_W;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    bst_pkg::back_state_t state_reg, state_next;
    bst_pkg::cmd_t        cmd_reg, cmd_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [SLOT_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                 hit_reg, hit_next;
    logic [SLOT_W-1:0]    hit_idx_reg, hit_idx_next;
    logic                 free_reg, free_next;
    logic [SLOT_W-1:0]    free_idx_reg, free_idx_next;
    logic [SLOTS-1:0]     valid_reg, valid_next;
    logic                 out_vld_reg, out_vld_next;
    logic                 found_reg, found_next;
    logic [bst_pkg::RSLOT_W-1:0] rslot_reg, rslot_next;
    bst_pkg::status_t     status_reg, status_next;

    logic [ID_W-1:0]      obj_mem [SLOTS];
    logic [ID_W-1:0]      rd_data_reg;
    logic                 rd_en;
    logic [SLOT_W-1:0]    rd_addr;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_waddr;

    logic                 out_free;
    logic                 hit_now;
    logic                 cnt_done;
    logic [SLOT_W-1:0]    cnt_idx;
    logic [SLOT_W-1:0]    sidx;

    assign empty       = !out_vld_reg;
    assign found       = found_reg;
    assign result_slot = rslot_reg;
    assign status      = status_reg;

    assign out_free = !out_vld_reg || pop;
    assign cnt_idx  = cnt_reg[SLOT_W-1:0];
    assign cnt_done = (cnt_reg == CNT_W'(SLOTS));
    assign sidx     = cmd_reg.sidx[SLOT_W-1:0];
    assign hit_now  = chk_vld_reg && valid_reg[chk_idx_reg] && (rd_data_reg == id_reg);
    assign rd_addr  = cnt_idx;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        cnt_next      = cnt_reg;
        chk_vld_next  = 1'b0;
        chk_idx_next  = chk_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        valid_next    = valid_reg;
        out_vld_next  = out_vld_reg && !pop;
        found_next    = found_reg;
        rslot_next    = rslot_reg;
        status_next   = status_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = free_idx_reg;

        unique case (state_reg)
            bst_pkg::S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    id_next    = q_id;
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    state_next = q_cmd.scan ? bst_pkg::S_SCAN : bst_pkg::S_EXEC;
                end
            end

            bst_pkg::S_SCAN:
            begin
                if (hit_now)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = chk_idx_reg;
                    state_next   = bst_pkg::S_EXEC;
                end
                else if (cnt_done)
                begin
                    state_next = bst_pkg::S_EXEC;
                end
                else
                begin
                    rd_en        = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = cnt_idx;
                    cnt_next     = CNT_W'(cnt_reg + 1'b1);
                    if (!free_reg && !valid_reg[cnt_idx])
                    begin
                        free_next     = 1'b1;
                        free_idx_next = cnt_idx;
                    end
                end
            end

            bst_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    found_next   = 1'b0;
                    rslot_next   = '0;
                    status_next  = bst_pkg::ST_OK;
                    state_next   = bst_pkg::S_IDLE;
                    case (cmd_reg.kind) inside
                        bst_pkg::K_BIND:
                        begin
                            if (cmd_reg.null_id)
                            begin
                                status_next = bst_pkg::ST_NULL;
                            end
                            else if (hit_reg)
                            begin
                                found_next = 1'b1;
                                rslot_next = bst_pkg::RSLOT_W'(hit_idx_reg);
                            end
                            else if (free_reg)
                            begin
                                mem_we                   = 1'b1;
                                valid_next[free_idx_reg] = 1'b1;
                                found_next               = 1'b1;
                                rslot_next = bst_pkg::RSLOT_W'(free_idx_reg);
                            end
                            else
                            begin
                                status_next = bst_pkg::ST_NOFREE;
                            end
                        end
                        bst_pkg::K_BIND_SLOT:
                        begin
                            if (hit_reg)
                            begin
                                found_next  = 1'b1;
                                rslot_next  = bst_pkg::RSLOT_W'(hit_idx_reg);
                                status_next = bst_pkg::ST_ALREADY;
                            end
                            else if (!cmd_reg.slot_ok)
                            begin
                                status_next = bst_pkg::ST_BADSLOT;
                            end
                            else
                            begin
                                mem_we           = !cmd_reg.null_id;
                                mem_waddr        = sidx;
                                valid_next[sidx] = !cmd_reg.null_id;
                                found_next       = 1'b1;
                                rslot_next       = bst_pkg::RSLOT_W'(sidx);
                            end
                        end
                        bst_pkg::K_UNBIND_ID,
                        bst_pkg::K_QUERY:
                        begin
                            if (cmd_reg.null_id)
                            begin
                                status_next = bst_pkg::ST_NULL;
                            end
                            else if (!hit_reg)
                            begin
                                status_next = bst_pkg::ST_NOTBOUND;
                            end
                            else
                            begin
                                if (cmd_reg.kind == bst_pkg::K_UNBIND_ID)
                                begin
                                    valid_next[hit_idx_reg] = 1'b0;
                                end
                                found_next = 1'b1;
                                rslot_next = bst_pkg::RSLOT_W'(hit_idx_reg);
                            end
                        end
                        bst_pkg::K_UNBIND_SLOT:
                        begin
                            if (!cmd_reg.slot_ok)
                            begin
                                status_next = bst_pkg::ST_BADSLOT;
                            end
                            else if (!valid_reg[sidx])
                            begin
                                status_next = bst_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                valid_next[sidx] = 1'b0;
                                found_next       = 1'b1;
                                rslot_next       = bst_pkg::RSLOT_W'(sidx);
                            end
                        end
                        bst_pkg::K_UNBIND_ALL:
                        begin
                            valid_next = '0;
                        end
                        default:
                        begin
                            status_next = bst_pkg::ST_OK;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = bst_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bst_pkg::S_IDLE;
            chk_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            cnt_reg     <= '0;
            valid_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chk_vld_reg <= chk_vld_next;
            hit_reg     <= hit_next;
            free_reg    <= free_next;
            cnt_reg     <= cnt_next;
            valid_reg   <= valid_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        chk_idx_reg  <= chk_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        found_reg    <= found_next;
        rslot_reg    <= rslot_next;
        status_reg   <= status_next;
    end

    // object store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            obj_mem[mem_waddr] <= id_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= obj_mem[rd_addr];
        end
    end

endmodule

### bench/bind_slot_table_checker.sv
// Checker for bind_slot_table: mirrors the slot table, predicts one reply word per
// request word and compares every popped reply against the oldest prediction.
// Depends on bst_pkg.
`timescale 1ns / 100ps

module bind_slot_table_checker
    import bst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  logic [OPC_W-1:0]    opcode,
    input  logic [OBJ_W-1:0]    object_id,
    input  logic [SIDX_W-1:0]   slot_index,
    input  logic                empty,
    input  logic                pop,
    input  logic                found,
    input  logic [RSLOT_W-1:0]  result_slot,
    input  logic [2:0]          status,
    output int                  mismatch_count,
    output int                  words_in_flight
);

    localparam int SLOTS = SLOTS_DEF;

    typedef struct packed {
        logic               found;
        logic [RSLOT_W-1:0] slot;
        status_t            status;
    } binding_reply_t;

    logic               slot_used [SLOTS];
    logic [OBJ_W-1:0]   slot_id   [SLOTS];
    binding_reply_t     expected_replies [$];

    initial
    begin
        mismatch_count  = 0;
        words_in_flight = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    function automatic int lookup_id(input logic [OBJ_W-1:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int lowest_free();
        for (int i = 0; i < SLOTS; i++)
            if (!slot_used[i])
                return i;
        return -1;
    endfunction

    function automatic binding_reply_t predict_binding(input logic [OPC_W-1:0] op,
                                                       input logic [OBJ_W-1:0] id,
                                                       input logic [SIDX_W-1:0] sidx);
        binding_reply_t r;
        int             hit;
        int             free_slot;
        logic           in_range;
        r.found   = 1'b0;
        r.slot    = '0;
        r.status  = ST_OK;
        in_range  = (sidx < SLOTS);
        hit       = (id != 0) ? lookup_id(id) : -1;
        case (op)
            OPC_BIND:
                if (id == 0)
                    r.status = ST_NULL;
                else if (hit >= 0)
                begin
                    r.found = 1'b1;
                    r.slot  = RSLOT_W'(hit);
                end
                else
                begin
                    free_slot = lowest_free();
                    if (free_slot < 0)
                        r.status = ST_NOFREE;
                    else
                    begin
                        slot_used[free_slot] = 1'b1;
                        slot_id[free_slot]   = id;
                        r.found = 1'b1;
                        r.slot  = RSLOT_W'(free_slot);
                    end
                end
            OPC_BIND_SLOT:
                if (hit >= 0)
                begin
                    r.found  = 1'b1;
                    r.slot   = RSLOT_W'(hit);
                    r.status = ST_ALREADY;
                end
                else if (!in_range)
                    r.status = ST_BADSLOT;
                else
                begin
                    slot_used[sidx] = (id != 0);
                    slot_id[sidx]   = id;
                    r.found = 1'b1;
                    r.slot  = RSLOT_W'(sidx);
                end
            OPC_UNBIND_ID:
                if (id == 0)
                    r.status = ST_NULL;
                else if (hit < 0)
                    r.status = ST_NOTBOUND;
                else
                begin
                    slot_used[hit] = 1'b0;
                    r.found = 1'b1;
                    r.slot  = RSLOT_W'(hit);
                end
            OPC_UNBIND_SLOT:
                if (!in_range)
                    r.status = ST_BADSLOT;
                else if (!slot_used[sidx])
                    r.status = ST_EMPTY;
                else
                begin
                    slot_used[sidx] = 1'b0;
                    r.found = 1'b1;
                    r.slot  = RSLOT_W'(sidx);
                end
            OPC_UNBIND_ALL:
                for (int i = 0; i < SLOTS; i++)
                    slot_used[i] = 1'b0;
            OPC_QUERY:
                if (id == 0)
                    r.status = ST_NULL;
                else if (hit < 0)
                    r.status = ST_NOTBOUND;
                else
                begin
                    r.found = 1'b1;
                    r.slot  = RSLOT_W'(hit);
                end
            default:
                ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        binding_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_used[i] = 1'b0;
                slot_id[i]   = '0;
            end
            expected_replies.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_replies.size() == 0)
                    report_mismatch("reply word with none pending",
                                    32'({found, result_slot, status}), 32'h0);
                else
                begin
                    want = expected_replies.pop_front();
                    if (found !== want.found)
                        report_mismatch("found", 32'(found), 32'(want.found));
                    if (result_slot !== want.slot)
                        report_mismatch("result_slot", 32'(result_slot), 32'(want.slot));
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                end
            end
            if (push && !full)
                expected_replies.push_back(predict_binding(opcode, object_id, slot_index));
        end
        words_in_flight = expected_replies.size();
    end

endmodule

### bench/tb_bind_slot_table.sv
// Testbench top for bind_slot_table: clock, reset, request stimulus and verdict.
// Depends on bst_pkg, bind_slot_table and bind_slot_table_checker.
`timescale 1ns / 100ps

module tb_bind_slot_table;
    import bst_pkg::*;

    localparam logic [OPC_W-1:0] OPC_SPARE_LO = 3'd6;
    localparam logic [OPC_W-1:0] OPC_SPARE_HI = 3'd7;
    localparam int POOL_IDS     = 24;
    localparam int RANDOM_WORDS = 760;
    localparam int CALM_WORDS   = 120;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [OPC_W-1:0]    opcode;
    logic [OBJ_W-1:0]    object_id;
    logic [SIDX_W-1:0]   slot_index;
    logic                empty;
    logic                pop;
    logic                found;
    logic [RSLOT_W-1:0]  result_slot;
    logic [2:0]          status;
    int                  mismatch_count;
    int                  words_in_flight;

    logic                calm;
    logic                send_steady;
    logic                drain_steady;
    logic [OBJ_W-1:0]    id_pool [POOL_IDS];

    bind_slot_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .object_id   (object_id),
        .slot_index  (slot_index),
        .empty       (empty),
        .pop         (pop),
        .found       (found),
        .result_slot (result_slot),
        .status      (status)
    );

    bind_slot_table_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .opcode          (opcode),
        .object_id       (object_id),
        .slot_index      (slot_index),
        .empty           (empty),
        .pop             (pop),
        .found           (found),
        .result_slot     (result_slot),
        .status          (status),
        .mismatch_count  (mismatch_count),
        .words_in_flight (words_in_flight)
    );

    initial
        clk = 1'b0;

    always #6 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("tb_bind_slot_table: done, errors");
        $finish;
    end

    task automatic send_word(input logic [OPC_W-1:0] op, input logic [OBJ_W-1:0] id,
                             input logic [SIDX_W-1:0] sidx);
        if ($urandom_range(0, 31) == 0)
            send_steady = !send_steady;
        if (!calm && !send_steady && $urandom_range(0, 2) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        push       <= 1'b1;
        opcode     <= op;
        object_id  <= id;
        slot_index <= sidx;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    function automatic logic [OBJ_W-1:0] pick_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 15)
            return $urandom;
        return id_pool[$urandom_range(0, POOL_IDS - 1)];
    endfunction

    function automatic logic [SIDX_W-1:0] pick_slot();
        if ($urandom_range(0, 99) < 85)
            return SIDX_W'($urandom_range(0, SLOTS_DEF - 1));
        return SIDX_W'($urandom_range(SLOTS_DEF, 31));
    endfunction

    function automatic logic [OPC_W-1:0] pick_op(input int roll);
        if (roll < 35)
            return OPC_BIND;
        if (roll < 50)
            return OPC_BIND_SLOT;
        if (roll < 62)
            return OPC_UNBIND_ID;
        if (roll < 72)
            return OPC_UNBIND_SLOT;
        if (roll < 74)
            return OPC_UNBIND_ALL;
        if (roll < 92)
            return OPC_QUERY;
        if (roll < 96)
            return OPC_SPARE_LO;
        return OPC_SPARE_HI;
    endfunction

    // reply drain side
    initial
    begin
        pop          <= 1'b0;
        drain_steady <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 47) == 0)
                drain_steady = !drain_steady;
            if (!calm && !drain_steady && $urandom_range(0, 2) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        int n;
        int roll;
        int base;
        rst_n       <= 1'b0;
        push        <= 1'b0;
        opcode      <= OPC_BIND;
        object_id   <= '0;
        slot_index  <= '0;
        calm        = 1'b0;
        send_steady = 1'b0;
        id_pool[0] = 32'hFFFF_FFFF;
        id_pool[1] = 32'h0000_0001;
        id_pool[2] = 32'h8000_0000;
        for (int i = 3; i < POOL_IDS; i++)
        begin
            id_pool[i] = $urandom;
            if (id_pool[i] == 0)
                id_pool[i] = 32'h5A5A_A5A5;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: null ids, hits, overwrite, invalid slots, empty slots, spare opcodes
        send_word(OPC_BIND,        '0,           5'd0);
        send_word(OPC_BIND,        32'hFFFF_FFFF, 5'd0);
        send_word(OPC_BIND,        32'hFFFF_FFFF, 5'd31);
        send_word(OPC_BIND_SLOT,   32'h0000_0001, 5'd15);
        send_word(OPC_BIND_SLOT,   32'h0000_0001, 5'd3);
        send_word(OPC_BIND_SLOT,   32'h1234_5678, 5'd31);
        send_word(OPC_BIND_SLOT,   32'h1234_5678, 5'd16);
        send_word(OPC_BIND_SLOT,   32'hABCD_0000, 5'd0);
        send_word(OPC_BIND_SLOT,   '0,           5'd0);
        send_word(OPC_QUERY,       32'hFFFF_FFFF, 5'd0);
        send_word(OPC_QUERY,       32'h0000_0001, 5'd0);
        send_word(OPC_QUERY,       '0,           5'd0);
        send_word(OPC_UNBIND_ID,   '0,           5'd0);
        send_word(OPC_UNBIND_ID,   32'h0000_0001, 5'd0);
        send_word(OPC_UNBIND_ID,   32'h0000_0001, 5'd0);
        send_word(OPC_UNBIND_SLOT, '0,           5'd15);
        send_word(OPC_UNBIND_SLOT, '0,           5'd20);
        send_word(OPC_BIND,        32'h8000_0000, 5'd7);
        send_word(OPC_UNBIND_SLOT, '0,           5'd0);
        send_word(OPC_SPARE_LO,    32'hFFFF_FFFF, 5'd31);
        send_word(OPC_SPARE_HI,    32'h0000_0001, 5'd1);
        send_word(OPC_BIND,        32'h0000_0002, 5'd0);
        send_word(OPC_UNBIND_ALL,  32'hFFFF_FFFF, 5'd31);
        send_word(OPC_QUERY,       32'h0000_0002, 5'd0);

        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS - CALM_WORDS)
                calm = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                // more distinct ids than slots, so the table runs out
                base = $urandom_range(0, POOL_IDS - 1);
                for (int k = 0; k <= SLOTS_DEF; k++)
                    send_word(OPC_BIND, id_pool[(base + k) % POOL_IDS], pick_slot());
            end
            else
                send_word(pick_op($urandom_range(0, 99)), pick_id(), pick_slot());
        end
        push <= 1'b0;

        while (words_in_flight != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && words_in_flight == 0)
            $display("tb_bind_slot_table: done, clean");
        else
            $display("tb_bind_slot_table: done, errors");
        $finish;
    end

endmodule
